[rtl/core/sha256_pkg.sv]
package sha256_pkg;

  // request and response transactions
  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } rsp_t;

  // request codes
  localparam logic REQ_ABSORB = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_ONE,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_COMPRESS,
    ST_ADD,
    ST_OUTPUT
  } state_t;

  // what the running compression belongs to
  typedef enum logic [1:0] {
    PH_ABSORB,
    PH_PAD,
    PH_FINAL
  } phase_t;

  // byte positions in the 64-byte block, last round and word, pad byte and block size
  localparam logic [5:0] FILL_LAST    = 6'd63;
  localparam logic [5:0] FILL_PRE_LEN = 6'd55;
  localparam logic [5:0] ROUND_LAST   = 6'd63;
  localparam logic [2:0] WORD_LAST    = 3'd7;
  localparam logic [7:0] PAD_MARK     = 8'h80;
  localparam logic [63:0] BLOCK_BITS  = 64'd512;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

[rtl/core/sha256_byte_stream_hasher.sv]
// SHA-256 hasher fed one byte per request transaction.
// Request channel (req_valid/req_ready/req): req_type absorb adds data_byte
// to the current 64-byte block; req_type finish pads the message, runs the
// last compression(s) and returns the digest.
// Response channel (rsp_valid/rsp_ready/rsp): eight transactions per finish,
// digest_word most significant first, word_index 0..7, last_word on the 8th.
// An absorb is taken while idle; the byte that completes a block then runs
// a compression: 64 rounds on the single round unit, then the chaining add.
// No further bytes are taken until that compression is done.
// A finish pads the message one byte at a time (64 - fill padding bytes, or
// 128 - fill when 56 or more bytes are buffered, so at most 72), compresses
// each padded block, then returns the eight digest words, one per cycle while
// rsp_ready is high.
// The block takes one request at a time; req_ready is low while it works.
// A stalled receiver holds the current digest word on rsp until taken.
// Reset (rst, synchronous) loads the initial hash values, clears the byte
// and bit counts and returns to idle; the same happens after the last word.
module sha256_byte_stream_hasher (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  sha256_pkg::req_t   req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output sha256_pkg::rsp_t   rsp
);

  sha256_pkg::state_t state, state_next;
  sha256_pkg::phase_t phase;

  logic [511:0] blk;
  logic [31:0]  chain [8];
  logic [31:0]  v [8];
  logic [5:0]   fill;
  logic [5:0]   round;
  logic [63:0]  message_bits;
  logic [63:0]  len_bits;
  logic [2:0]   word_idx;

  // round unit signals
  logic [31:0] w_cur, w_1, w_9, w_14, s0, s1, w_new;
  logic [31:0] big0, big1, ch, maj, t1, t2;

  // message schedule taps on the block shift line
  assign w_cur = blk[511:480];
  assign w_1   = blk[479:448];
  assign w_9   = blk[223:192];
  assign w_14  = blk[63:32];
  assign s0    = {w_1[6:0], w_1[31:7]} ^ {w_1[17:0], w_1[31:18]} ^ (w_1 >> 3);
  assign s1    = {w_14[16:0], w_14[31:17]} ^ {w_14[18:0], w_14[31:19]} ^ (w_14 >> 10);
  assign w_new = s1 + w_9 + s0 + w_cur;

  // compression round
  assign big1 = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]}
              ^ {v[4][24:0], v[4][31:25]};
  assign ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign t1   = v[7] + big1 + ch + sha256_pkg::ROUND_K[round] + w_cur;
  assign big0 = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]}
              ^ {v[0][21:0], v[0][31:22]};
  assign maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t2   = big0 + maj;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sha256_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (req.req_type == sha256_pkg::REQ_FINISH) begin
            state_next = sha256_pkg::ST_PAD_ONE;
          end else if (fill == sha256_pkg::FILL_LAST) begin
            state_next = sha256_pkg::ST_COMPRESS;
          end
        end
      end
      sha256_pkg::ST_PAD_ONE, sha256_pkg::ST_PAD_ZERO: begin
        if (fill == sha256_pkg::FILL_LAST) begin
          state_next = sha256_pkg::ST_COMPRESS;
        end else if (fill == sha256_pkg::FILL_PRE_LEN) begin
          state_next = sha256_pkg::ST_PAD_LEN;
        end else begin
          state_next = sha256_pkg::ST_PAD_ZERO;
        end
      end
      sha256_pkg::ST_PAD_LEN: begin
        if (fill == sha256_pkg::FILL_LAST) begin
          state_next = sha256_pkg::ST_COMPRESS;
        end
      end
      sha256_pkg::ST_COMPRESS: begin
        if (round == sha256_pkg::ROUND_LAST) begin
          state_next = sha256_pkg::ST_ADD;
        end
      end
      sha256_pkg::ST_ADD: begin
        unique case (phase)
          sha256_pkg::PH_ABSORB: state_next = sha256_pkg::ST_IDLE;
          sha256_pkg::PH_PAD:    state_next = sha256_pkg::ST_PAD_ZERO;
          sha256_pkg::PH_FINAL:  state_next = sha256_pkg::ST_OUTPUT;
          default:               state_next = sha256_pkg::ST_IDLE;
        endcase
      end
      sha256_pkg::ST_OUTPUT: begin
        if (rsp_ready && word_idx == sha256_pkg::WORD_LAST) begin
          state_next = sha256_pkg::ST_IDLE;
        end
      end
      default: state_next = sha256_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    req_ready       = (state == sha256_pkg::ST_IDLE);
    rsp_valid       = (state == sha256_pkg::ST_OUTPUT);
    rsp.digest_word = chain[word_idx];
    rsp.word_index  = word_idx;
    rsp.last_word   = (word_idx == sha256_pkg::WORD_LAST);
  end

  // control and chaining state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sha256_pkg::ST_IDLE;
      phase        <= sha256_pkg::PH_ABSORB;
      fill         <= '0;
      round        <= '0;
      message_bits <= '0;
      word_idx     <= '0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= sha256_pkg::INIT_H[i];
      end
    end else begin
      state <= state_next;
      // compression start: tag the phase and clear the round count
      if (state_next == sha256_pkg::ST_COMPRESS && state != sha256_pkg::ST_COMPRESS) begin
        round <= '0;
        if (state == sha256_pkg::ST_IDLE) begin
          phase <= sha256_pkg::PH_ABSORB;
        end else if (state == sha256_pkg::ST_PAD_LEN) begin
          phase <= sha256_pkg::PH_FINAL;
        end else begin
          phase <= sha256_pkg::PH_PAD;
        end
      end
      unique case (state)
        sha256_pkg::ST_IDLE: begin
          if (req_valid && req.req_type == sha256_pkg::REQ_ABSORB) begin
            fill <= fill + 6'd1;
          end
        end
        sha256_pkg::ST_PAD_ONE, sha256_pkg::ST_PAD_ZERO, sha256_pkg::ST_PAD_LEN: begin
          fill <= fill + 6'd1;
        end
        sha256_pkg::ST_COMPRESS: begin
          round <= round + 6'd1;
        end
        sha256_pkg::ST_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + v[i];
          end
          if (phase == sha256_pkg::PH_ABSORB) begin
            message_bits <= message_bits + sha256_pkg::BLOCK_BITS;
          end
        end
        sha256_pkg::ST_OUTPUT: begin
          if (rsp_ready) begin
            word_idx <= word_idx + 3'd1;
            // last word taken: back to a fresh message
            if (word_idx == sha256_pkg::WORD_LAST) begin
              fill         <= '0;
              message_bits <= '0;
              for (int i = 0; i < 8; i++) begin
                chain[i] <= sha256_pkg::INIT_H[i];
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // block shift line, length shifter and working variables
  always_ff @(posedge clk) begin
    unique case (state)
      sha256_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (req.req_type == sha256_pkg::REQ_ABSORB) begin
            blk <= {blk[503:0], req.data_byte};
          end else begin
            len_bits <= message_bits + {55'd0, fill, 3'd0};
          end
        end
      end
      sha256_pkg::ST_PAD_ONE: begin
        blk <= {blk[503:0], sha256_pkg::PAD_MARK};
      end
      sha256_pkg::ST_PAD_ZERO: begin
        blk <= {blk[503:0], 8'd0};
      end
      sha256_pkg::ST_PAD_LEN: begin
        blk      <= {blk[503:0], len_bits[63:56]};
        len_bits <= {len_bits[55:0], 8'd0};
      end
      sha256_pkg::ST_COMPRESS: begin
        blk  <= {blk[479:0], w_new};
        v[7] <= v[6];
        v[6] <= v[5];
        v[5] <= v[4];
        v[4] <= v[3] + t1;
        v[3] <= v[2];
        v[2] <= v[1];
        v[1] <= v[0];
        v[0] <= t1 + t2;
      end
      default: begin
      end
    endcase
    // working variables start from the chaining words
    if (state_next == sha256_pkg::ST_COMPRESS && state != sha256_pkg::ST_COMPRESS) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= chain[i];
      end
    end
  end

endmodule

[rtl/core/sha256_checker.sv]
module sha256_checker (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input sha256_pkg::rsp_t rsp
);

  // one request at a time: never taking requests while the digest is out
  assert property (@(posedge clk) disable iff (rst) rsp_valid |-> !req_ready)
    else $error("request taken while digest pending");

  // last_word marks exactly the final digest position
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.last_word == (rsp.word_index == sha256_pkg::WORD_LAST)))
    else $error("last_word does not match word_index");

  // an accepted request never yields a digest word in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !rsp_valid)
    else $error("digest word too early after request");

  // after the last word the block is idle again
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_ready && rsp.last_word) |=> (req_ready && !rsp_valid))
    else $error("not idle after final digest word");

  // stalled digest word holds
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled digest transaction changed");

endmodule

bind sha256_byte_stream_hasher sha256_checker u_sha256_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

[verif/sha256_byte_stream_hasher_test.sv]
`timescale 1ns / 100ps

module sha256_byte_stream_hasher_test;

  localparam int unsigned ITEM_TARGET    = 430;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 300;
  localparam int unsigned MAX_SHOWN      = 10;
  localparam int unsigned BOUNDARY_LENGTHS [4] = '{55, 56, 63, 64};

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_SPARSE,
    RDY_TOGGLE,
    RDY_COIN
  } ready_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  sha256_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  sha256_pkg::rsp_t rsp;

  // digest model state
  logic [31:0] chain_h [8];
  logic [7:0]  block_bytes [64];
  logic [5:0]  block_count;
  logic [63:0] hashed_bits;
  sha256_pkg::rsp_t pending_digest_words [$];

  int unsigned burst_left = 0;
  int unsigned sent_count = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  ready_mode_t ready_mode = RDY_ALWAYS;
  int unsigned ready_span = 0;

  sha256_byte_stream_hasher DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // clock
  always #2 clk = ~clk;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // back to the initial hash values, empty buffer
  task automatic clear_digest_state();
    for (int j = 0; j < 8; j++) chain_h[j] = sha256_pkg::INIT_H[j];
    for (int j = 0; j < 64; j++) block_bytes[j] = 8'h00;
    block_count = '0;
    hashed_bits = '0;
  endtask

  // 64-round compression of the buffered block into the chaining words
  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
    for (int r = 0; r < 16; r++)
      w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
    for (int r = 16; r < 64; r++) begin
      s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
      s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
      w[r] = s1 + w[r-7] + s0 + w[r-16];
    end
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
    e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; hh = chain_h[7];
    for (int r = 0; r < 64; r++) begin
      t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + sha256_pkg::ROUND_K[r] + w[r];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      hh = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += hh;
  endtask

  // one message byte into the buffer, compress when the block fills
  task automatic absorb_byte(input logic [7:0] value);
    block_bytes[block_count] = value;
    block_count = block_count + 1'b1;
    if (block_count == '0) begin
      compress_block();
      hashed_bits = hashed_bits + sha256_pkg::BLOCK_BITS;
    end
  endtask

  // padding, final compression(s), then the eight expected digest words
  task automatic finish_digest();
    logic [63:0] total_bits;
    sha256_pkg::rsp_t word;
    total_bits = hashed_bits + {55'd0, block_count, 3'b000};
    block_bytes[block_count] = sha256_pkg::PAD_MARK;
    for (int j = block_count + 1; j < 64; j++) block_bytes[j] = 8'h00;
    // long tail: length does not fit, spill into a second block
    if (block_count > sha256_pkg::FILL_PRE_LEN) begin
      compress_block();
      for (int j = 0; j <= sha256_pkg::FILL_PRE_LEN; j++) block_bytes[j] = 8'h00;
    end
    for (int j = 0; j < 8; j++)
      block_bytes[sha256_pkg::FILL_PRE_LEN + 1 + j] = total_bits[63 - 8*j -: 8];
    compress_block();
    for (int j = 0; j < 8; j++) begin
      word.digest_word = chain_h[j];
      word.word_index  = 3'(j);
      word.last_word   = (3'(j) == sha256_pkg::WORD_LAST);
      pending_digest_words.push_back(word);
    end
    clear_digest_state();
  endtask

  // drive one request transaction, bursts separated by random gaps
  task automatic send_req(input logic kind, input logic [7:0] value);
    int unsigned gap;
    gap = 0;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
    end
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= {kind, value};
    do @(posedge clk); while (!req_ready);
    burst_left--;
    sent_count++;
    if (kind == sha256_pkg::REQ_FINISH) finish_digest();
    else absorb_byte(value);
  endtask

  task automatic send_message(input int unsigned length);
    for (int unsigned j = 0; j < length; j++)
      send_req(sha256_pkg::REQ_ABSORB, 8'($urandom));
    send_req(sha256_pkg::REQ_FINISH, 8'($urandom));
  endtask

  // hold off the sender until every digest word has come back
  task automatic drain_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_digest_words.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_message();
    send_req(sha256_pkg::REQ_FINISH, 8'hff);
  endtask

  task automatic test_byte_extremes();
    send_req(sha256_pkg::REQ_ABSORB, 8'h00);
    send_req(sha256_pkg::REQ_FINISH, 8'h00);
    send_req(sha256_pkg::REQ_ABSORB, 8'hff);
    send_req(sha256_pkg::REQ_FINISH, 8'hff);
    send_req(sha256_pkg::REQ_ABSORB, 8'h00);
    send_req(sha256_pkg::REQ_ABSORB, 8'hff);
    send_req(sha256_pkg::REQ_ABSORB, 8'h00);
    send_req(sha256_pkg::REQ_ABSORB, 8'hff);
    send_req(sha256_pkg::REQ_FINISH, 8'h00);
  endtask

  // "abc" then an empty message right behind it
  task automatic test_known_vector();
    send_req(sha256_pkg::REQ_ABSORB, 8'h61);
    send_req(sha256_pkg::REQ_ABSORB, 8'h62);
    send_req(sha256_pkg::REQ_ABSORB, 8'h63);
    send_req(sha256_pkg::REQ_FINISH, 8'h5a);
    send_req(sha256_pkg::REQ_FINISH, 8'ha5);
    drain_results();
  endtask

  // lengths around the padding split and the full block
  task automatic test_block_boundaries();
    for (int k = 0; k < 4; k++) send_message(BOUNDARY_LENGTHS[k]);
  endtask

  task automatic test_random_messages();
    int unsigned length;
    while (sent_count < ITEM_TARGET) begin
      length = ($urandom_range(4) == 0) ? $urandom_range(31, 70) : $urandom_range(0, 30);
      send_message(length);
      if ($urandom_range(4) == 0) drain_results();
    end
  endtask

  // main sequence
  initial begin
    clear_digest_state();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_empty_message();
    test_byte_extremes();
    test_known_vector();
    test_block_boundaries();
    test_random_messages();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_digest_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // receiver stall pattern, mode picked anew after each random span
  always @(negedge clk) begin
    if (ready_span == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(3));
      ready_span <= $urandom_range(8, 80);
    end else begin
      ready_span <= ready_span - 1;
    end
    case (ready_mode)
      RDY_ALWAYS: rsp_ready <= 1'b1;
      RDY_SPARSE: rsp_ready <= ($urandom_range(3) == 0);
      RDY_TOGGLE: rsp_ready <= ~rsp_ready;
      default:    rsp_ready <= 1'($urandom_range(1));
    endcase
  end

  // compare each response transaction with the oldest expected word
  always @(posedge clk) begin
    sha256_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_digest_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected digest word: word %h index %0d last %b",
                   rsp.digest_word, rsp.word_index, rsp.last_word);
      end else begin
        want = pending_digest_words.pop_front();
        if (rsp.digest_word !== want.digest_word || rsp.word_index !== want.word_index ||
            rsp.last_word !== want.last_word) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                     want.digest_word, want.word_index, want.last_word,
                     rsp.digest_word, rsp.word_index, rsp.last_word);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

[sha256_byte_stream_hasher.f]
rtl/core/sha256_pkg.sv
rtl/core/sha256_byte_stream_hasher.sv
rtl/core/sha256_checker.sv
verif/sha256_byte_stream_hasher_test.sv
